@@ design/rotation_matrix_to_quaternion_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the rotation matrix to quaternion unit
// Shared concurrent assertion forms, clocked on clk, off during rst.
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_DEFINES_SVH

// same-cycle implication
`define RMQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RMQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/rmq_pkg.sv @@
// ----------------------------------------------------------------------------
// rmq_pkg
// Types and constants of the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int SqrtSteps = 16;
  localparam int DivSteps  = 16;
  localparam int Lanes     = 3;

  typedef logic signed [15:0] fx_t;

  typedef enum logic [1:0] {
    SLOT_W = 2'd0,
    SLOT_X = 2'd1,
    SLOT_Y = 2'd2,
    SLOT_Z = 2'd3
  } slot_t;

  typedef struct packed {
    slot_t                   slot;
    logic                    bad;
    logic [Lanes-1:0]        neg;
    logic [Lanes-1:0][16:0]  mag;
  } side_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [15:0] root;
    side_t       side;
  } sq_t;

  typedef struct packed {
    logic [Lanes-1:0][31:0] rem;
    logic [Lanes-1:0][15:0] quo;
    logic [Lanes-1:0]       sat;
    logic [16:0]            dvs;
    logic [14:0]            half;
    slot_t                  slot;
    logic                   bad;
    logic [Lanes-1:0]       neg;
  } dv_t;

endpackage

@@ design/rmq_if.sv @@
// ----------------------------------------------------------------------------
// rmq_mat_if / rmq_quat_if
// Valid/ready channels for the input matrix and the output quaternion.
// ----------------------------------------------------------------------------
interface rmq_mat_if;
  logic          valid;
  logic          ready;
  rmq_pkg::fx_t  m00, m01, m02, m10, m11, m12, m20, m21, m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

interface rmq_quat_if;
  logic          valid;
  logic          ready;
  rmq_pkg::fx_t  quat_w, quat_x, quat_y, quat_z;
  logic          invalid;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, invalid,
                  input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, invalid,
                  output ready);
endinterface

@@ design/rmq_sqrt.sv @@
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`include "rotation_matrix_to_quaternion_unit_defines.svh"

module rmq_sqrt (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  rmq_pkg::sq_t in_data,
  output logic         out_valid,
  output rmq_pkg::sq_t out_data
);

  logic         vld [0:rmq_pkg::SqrtSteps];
  rmq_pkg::sq_t st  [0:rmq_pkg::SqrtSteps];

  assign vld[0] = in_valid;
  assign st[0]  = in_data;

  for (genvar s = 0; s < rmq_pkg::SqrtSteps; s++) begin : g_step
    localparam int B = rmq_pkg::SqrtSteps - 1 - s;
    logic [33:0]  term;
    rmq_pkg::sq_t nxt;

    always_comb begin
      term = (34'(st[s].root) << (B + 1)) + (34'd1 << (2 * B));
      nxt  = st[s];
      if (34'(st[s].rem) >= term) begin
        nxt.rem     = 32'(34'(st[s].rem) - term);
        nxt.root[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
      if (en) begin
        st[s+1] <= nxt;
      end
    end
  end

  assign out_valid = vld[rmq_pkg::SqrtSteps];
  assign out_data  = st[rmq_pkg::SqrtSteps];

  // a positive argument is at least one LSB, so the root is at least 128
  `RMQ_ASSERT_NOW(a_root_min, out_valid && !out_data.side.bad, out_data.root >= 16'd128, "root below minimum")
  `RMQ_ASSERT_NOW(a_root_max, out_valid, out_data.root <= 16'd46341, "root above range")

endmodule

@@ design/rmq_div.sv @@
// ----------------------------------------------------------------------------
// rmq_div
// Three-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rmq_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  rmq_pkg::dv_t in_data,
  output logic         out_valid,
  output rmq_pkg::dv_t out_data
);

  logic         vld [0:rmq_pkg::DivSteps];
  rmq_pkg::dv_t st  [0:rmq_pkg::DivSteps];

  assign vld[0] = in_valid;
  assign st[0]  = in_data;

  for (genvar s = 0; s < rmq_pkg::DivSteps; s++) begin : g_step
    localparam int B = rmq_pkg::DivSteps - 1 - s;
    logic [32:0]  sub;
    rmq_pkg::dv_t nxt;

    always_comb begin
      sub = 33'(st[s].dvs) << B;
      nxt = st[s];
      for (int l = 0; l < rmq_pkg::Lanes; l++) begin
        if (33'(st[s].rem[l]) >= sub) begin
          nxt.rem[l]    = 32'(33'(st[s].rem[l]) - sub);
          nxt.quo[l][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
      if (en) begin
        st[s+1] <= nxt;
      end
    end
  end

  assign out_valid = vld[rmq_pkg::DivSteps];
  assign out_data  = st[rmq_pkg::DivSteps];

endmodule

@@ design/rotation_matrix_to_quaternion_unit.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Rotation matrix to quaternion, Q2.14 in and out, fully pipelined.
//
//   channel  dir  payload
//   matrix   in   m00..m22, signed Q2.14
//   quat     out  quat_w..quat_z signed Q2.14, invalid
//
// Accepts one matrix per cycle while quat is not stalled; the stages are one setup stage,
// 16 square-root stages, one divisor stage, 16 divider stages and the output register.
// Reset clears the valid bits only.
// A stall on quat freezes every stage at once; ready follows the output register.
// ----------------------------------------------------------------------------
`include "rotation_matrix_to_quaternion_unit_defines.svh"

module rotation_matrix_to_quaternion_unit (
  input  logic               clk,
  input  logic               rst,
  rmq_mat_if.sink            matrix,
  rmq_quat_if.source         quat
);

  localparam logic signed [18:0] One = 19'sd16384;

  logic en;
  assign en           = !quat.valid || quat.ready;
  assign matrix.ready = en;

  // setup stage
  logic signed [17:0] trace, dx, dy, dz, s01, s02, s12;
  logic signed [18:0] arg, a0, a1, a2;
  logic signed [17:0] n [0:2];
  logic               sel1, sel2;
  rmq_pkg::fx_t       mii;
  rmq_pkg::sq_t       prep;
  logic               p_vld;
  rmq_pkg::sq_t       p_data;

  always_comb begin
    trace = 18'(matrix.m00) + 18'(matrix.m11) + 18'(matrix.m22);
    dx    = 18'(matrix.m21) - 18'(matrix.m12);
    dy    = 18'(matrix.m02) - 18'(matrix.m20);
    dz    = 18'(matrix.m10) - 18'(matrix.m01);
    s01   = 18'(matrix.m01) + 18'(matrix.m10);
    s02   = 18'(matrix.m02) + 18'(matrix.m20);
    s12   = 18'(matrix.m12) + 18'(matrix.m21);
    a0    = 19'(matrix.m00) - 19'(matrix.m11) - 19'(matrix.m22) + One;
    a1    = 19'(matrix.m11) - 19'(matrix.m22) - 19'(matrix.m00) + One;
    a2    = 19'(matrix.m22) - 19'(matrix.m00) - 19'(matrix.m11) + One;
    sel1  = matrix.m11 > matrix.m00;
    mii   = sel1 ? matrix.m11 : matrix.m00;
    sel2  = matrix.m22 > mii;
    prep  = '0;
    if (trace > 18'sd0) begin
      prep.side.slot = rmq_pkg::SLOT_W;
      arg  = 19'(trace) + One;
      n[0] = dx; n[1] = dy; n[2] = dz;
    end else if (sel2) begin
      prep.side.slot = rmq_pkg::SLOT_Z;
      arg  = a2;
      n[0] = dz; n[1] = s02; n[2] = s12;
    end else if (sel1) begin
      prep.side.slot = rmq_pkg::SLOT_Y;
      arg  = a1;
      n[0] = dy; n[1] = s01; n[2] = s12;
    end else begin
      prep.side.slot = rmq_pkg::SLOT_X;
      arg  = a0;
      n[0] = dx; n[1] = s01; n[2] = s02;
    end
    prep.side.bad = arg <= 19'sd0;
    prep.rem      = 32'(arg[16:0]) << 14;
    prep.root     = '0;
    for (int l = 0; l < rmq_pkg::Lanes; l++) begin
      prep.side.neg[l] = n[l] < 18'sd0;
      prep.side.mag[l] = n[l] < 18'sd0 ? 17'(-n[l]) : 17'(n[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (en) begin
      p_vld <= matrix.valid;
    end
    if (en) begin
      p_data <= prep;
    end
  end

  logic         sq_vld;
  rmq_pkg::sq_t sq_data;

  rmq_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p_vld),
    .in_data   (p_data),
    .out_valid (sq_vld),
    .out_data  (sq_data)
  );

  // divisor stage
  rmq_pkg::dv_t dprep;
  logic         d_vld;
  rmq_pkg::dv_t d_data;

  always_comb begin
    dprep      = '0;
    dprep.dvs  = {sq_data.root, 1'b0};
    dprep.half = 15'((17'(sq_data.root) + 17'd1) >> 1);
    dprep.slot = sq_data.side.slot;
    dprep.bad  = sq_data.side.bad;
    dprep.neg  = sq_data.side.neg;
    for (int l = 0; l < rmq_pkg::Lanes; l++) begin
      dprep.rem[l] = (32'(sq_data.side.mag[l]) << 14) + 32'(sq_data.root);
      dprep.sat[l] = 33'(dprep.rem[l]) >= (33'(dprep.dvs) << 16);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (en) begin
      d_vld <= sq_vld;
    end
    if (en) begin
      d_data <= dprep;
    end
  end

  logic         dv_vld;
  rmq_pkg::dv_t dv_data;

  rmq_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_vld),
    .in_data   (d_data),
    .out_valid (dv_vld),
    .out_data  (dv_data)
  );

  // output register
  rmq_pkg::fx_t lane [0:2];
  rmq_pkg::fx_t comp [0:3];
  logic         big;
  logic         o_vld;
  rmq_pkg::fx_t o_w, o_x, o_y, o_z;
  logic         o_bad;

  always_comb begin
    for (int l = 0; l < rmq_pkg::Lanes; l++) begin
      big = dv_data.sat[l] || dv_data.quo[l][15];
      if (dv_data.neg[l]) begin
        lane[l] = big ? -16'sd32768 : -$signed(dv_data.quo[l]);
      end else begin
        lane[l] = big ? 16'sd32767 : $signed(dv_data.quo[l]);
      end
    end
    for (int s = 0; s < 4; s++) begin
      if (dv_data.bad) begin
        comp[s] = '0;
      end else if (2'(s) == dv_data.slot) begin
        comp[s] = $signed({1'b0, dv_data.half});
      end else if (2'(s) < dv_data.slot) begin
        comp[s] = lane[s];
      end else begin
        comp[s] = lane[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (en) begin
      o_vld <= dv_vld;
    end
    if (en) begin
      o_w   <= comp[0];
      o_x   <= comp[1];
      o_y   <= comp[2];
      o_z   <= comp[3];
      o_bad <= dv_data.bad;
    end
  end

  assign quat.valid   = o_vld;
  assign quat.quat_w  = o_w;
  assign quat.quat_x  = o_x;
  assign quat.quat_y  = o_y;
  assign quat.quat_z  = o_z;
  assign quat.invalid = o_bad;

  `RMQ_ASSERT_NOW(a_bad_zero, quat.valid && quat.invalid, quat.quat_w == 16'sd0 && quat.quat_x == 16'sd0 && quat.quat_y == 16'sd0 && quat.quat_z == 16'sd0, "invalid result not zero")
  `RMQ_ASSERT_NOW(a_root_half, dv_vld && !dv_data.bad, dv_data.half != 15'd0, "root component is zero")
  `RMQ_ASSERT_NEXT(a_stall_freeze, !en, $stable(dv_vld) && $stable(d_vld), "pipeline moved in stall")

endmodule
